/* rtl/ibt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types and constants for the I2C master byte transmitter.
// ----------------------------------------------------------------------------
package ibt_pkg;

    localparam int unsigned CFG_W        = 16;
    localparam logic [CFG_W-1:0] HALF_BIT_RESET = 16'd50;
    localparam int unsigned BYTE_BITS    = 8;
    localparam int unsigned BITS_CNT_W   = 4;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SEND  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DLOW     = 3'd1,
        PH_DSTRETCH = 3'd2,
        PH_DHIGH    = 3'd3,
        PH_ALOW     = 3'd4,
        PH_ASTRETCH = 3'd5,
        PH_AHIGH    = 3'd6
    } t_phase;

    // Sticky failure bit positions
    localparam int unsigned FAIL_NO_ACK   = 0;
    localparam int unsigned FAIL_PROTOCOL = 1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       scl_high;
        logic       sda_high;
        logic       start_seen;
        logic       stop_seen;
    } t_item;

    typedef struct packed {
        logic scl_pull_low;
        logic sda_pull_low;
        logic busy_res;
        logic byte_done;
        logic no_ack_flag;
        logic protocol_fail_flag;
    } t_result;

endpackage

/* rtl/ibt_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_in_if
// Valid/ready channel carrying one bus tick item.
// ----------------------------------------------------------------------------
interface ibt_in_if;
    logic           valid;
    logic           ready;
    ibt_pkg::t_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* rtl/ibt_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_out_if
// Valid/ready channel carrying one bus drive/status result.
// ----------------------------------------------------------------------------
interface ibt_out_if;
    logic             valid;
    logic             ready;
    ibt_pkg::t_result res;

    modport source (output valid, output res, input ready);
    modport sink   (input valid, input res, output ready);
endinterface

/* rtl/ibt_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_core
// Bit sequencer state and one-tick next-state logic. The result reflects
// the state after the tick being stepped.
// ----------------------------------------------------------------------------
module ibt_core #(
    parameter int unsigned DELAY_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [DELAY_BITS-1:0]  i_half_bit,
    input  ibt_pkg::t_item         i_item,
    output ibt_pkg::t_result       o_res
);

    ibt_pkg::t_phase                    r_phase, n_phase;
    logic [ibt_pkg::BYTE_BITS-1:0]      r_shift, n_shift;
    logic [ibt_pkg::BITS_CNT_W-1:0]     r_bits,  n_bits;
    logic [DELAY_BITS-1:0]              r_delay, n_delay;
    logic                               r_scl,   n_scl;
    logic [1:0]                         r_fail,  n_fail;

    logic                  dly_done;
    logic [DELAY_BITS-1:0] dly_dec;
    logic                  cond;
    logic                  done;
    logic                  data_ph;

    assign dly_done = (r_delay <= DELAY_BITS'(1));
    assign dly_dec  = dly_done ? '0 : (r_delay - DELAY_BITS'(1));
    assign cond     = i_item.start_seen | i_item.stop_seen;

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_delay = r_delay;
        n_scl   = r_scl;
        n_fail  = r_fail;
        done    = 1'b0;

        // clear first, so a flag raised on this tick survives
        if (i_item.mode == ibt_pkg::MODE_CLEAR) begin
            n_fail = '0;
        end

        case (r_phase)
            ibt_pkg::PH_IDLE: begin
                if (i_item.mode == ibt_pkg::MODE_SEND) begin
                    n_shift = i_item.data_byte;
                    n_bits  = ibt_pkg::BITS_CNT_W'(ibt_pkg::BYTE_BITS);
                    n_delay = i_half_bit;
                    n_phase = ibt_pkg::PH_DLOW;
                end
            end
            ibt_pkg::PH_DLOW, ibt_pkg::PH_DSTRETCH, ibt_pkg::PH_DHIGH: begin
                if (cond) begin
                    n_fail[ibt_pkg::FAIL_PROTOCOL] = 1'b1;
                    n_phase = ibt_pkg::PH_IDLE;
                    done    = 1'b1;
                end else if (r_phase == ibt_pkg::PH_DLOW) begin
                    n_delay = dly_dec;
                    if (dly_done) begin
                        n_scl   = 1'b0;
                        n_phase = ibt_pkg::PH_DSTRETCH;
                    end
                end else if (r_phase == ibt_pkg::PH_DSTRETCH) begin
                    // wait out any clock stretching
                    if (i_item.scl_high) begin
                        n_delay = i_half_bit;
                        n_phase = ibt_pkg::PH_DHIGH;
                    end
                end else begin
                    n_delay = dly_dec;
                    if (dly_done) begin
                        n_scl   = 1'b1;
                        n_shift = {r_shift[ibt_pkg::BYTE_BITS-2:0], 1'b0};
                        n_bits  = r_bits - ibt_pkg::BITS_CNT_W'(1);
                        n_delay = i_half_bit;
                        n_phase = (n_bits == '0) ? ibt_pkg::PH_ALOW : ibt_pkg::PH_DLOW;
                    end
                end
            end
            ibt_pkg::PH_ALOW: begin
                n_delay = dly_dec;
                if (dly_done) begin
                    n_scl   = 1'b0;
                    n_phase = ibt_pkg::PH_ASTRETCH;
                end
            end
            ibt_pkg::PH_ASTRETCH: begin
                if (i_item.scl_high) begin
                    n_delay = i_half_bit;
                    n_phase = ibt_pkg::PH_AHIGH;
                end
            end
            ibt_pkg::PH_AHIGH: begin
                n_delay = dly_dec;
                if (dly_done) begin
                    // sample ACK on the last tick of the high half
                    if (i_item.sda_high) begin
                        n_fail[ibt_pkg::FAIL_NO_ACK] = 1'b1;
                    end
                    n_scl   = 1'b1;
                    n_phase = ibt_pkg::PH_IDLE;
                    done    = 1'b1;
                end
            end
            default: begin
                n_phase = ibt_pkg::PH_IDLE;
            end
        endcase
    end

    assign data_ph = (n_phase == ibt_pkg::PH_DLOW) || (n_phase == ibt_pkg::PH_DSTRETCH) ||
                     (n_phase == ibt_pkg::PH_DHIGH);

    always_comb begin
        o_res.scl_pull_low       = n_scl;
        o_res.sda_pull_low       = data_ph && !n_shift[ibt_pkg::BYTE_BITS-1];
        o_res.busy_res           = (n_phase != ibt_pkg::PH_IDLE);
        o_res.byte_done          = done;
        o_res.no_ack_flag        = n_fail[ibt_pkg::FAIL_NO_ACK];
        o_res.protocol_fail_flag = n_fail[ibt_pkg::FAIL_PROTOCOL];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ibt_pkg::PH_IDLE;
            r_shift <= '0;
            r_bits  <= '0;
            r_delay <= '0;
            r_scl   <= 1'b0;
            r_fail  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_delay <= n_delay;
            r_scl   <= n_scl;
            r_fail  <= n_fail;
        end
    end

endmodule

/* rtl/i2c_master_byte_transmitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_transmitter
// Single-master I2C byte writer with ACK check, stepped by one tick item.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  i_in_ch    in   valid/ready    mode, data_byte, scl_high, sda_high,
//                                 start_seen, stop_seen
//  o_out_ch   out  valid/ready    scl_pull_low, sda_pull_low, busy_res,
//                                 byte_done, no_ack_flag, protocol_fail_flag
//  cfg        in   i_cfg_we       half_bit_ticks
//
//  An item is held in the input register, then steps the sequencer and
//  lands in the result register; one item per cycle is sustained while
//  the result is not stalled. A stalled result holds the input register,
//  which in turn drops ready. Synchronous reset returns the sequencer to
//  idle with SCL and SDA released and half_bit_ticks at 50.
// ----------------------------------------------------------------------------
module i2c_master_byte_transmitter #(
    parameter int unsigned DELAY_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ibt_pkg::CFG_W-1:0]      i_cfg_wdata,
    ibt_in_if.sink                         i_in_ch,
    ibt_out_if.source                      o_out_ch
);

    logic [ibt_pkg::CFG_W-1:0] r_half_bit;
    logic [DELAY_BITS-1:0]     half_bit;
    ibt_pkg::t_item            r_in;
    logic                      r_in_vld;
    ibt_pkg::t_result          r_out;
    logic                      r_out_vld;
    ibt_pkg::t_result          step_res;
    logic                      fire;

    generate
        if (DELAY_BITS >= ibt_pkg::CFG_W) begin : g_ext
            assign half_bit = DELAY_BITS'(r_half_bit);
        end else begin : g_trunc
            assign half_bit = r_half_bit[DELAY_BITS-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit <= ibt_pkg::HALF_BIT_RESET;
        end else if (i_cfg_we) begin
            r_half_bit <= i_cfg_wdata;
        end
    end

    assign fire           = r_in_vld && (!r_out_vld || o_out_ch.ready);
    assign i_in_ch.ready  = !r_in_vld || fire;
    assign o_out_ch.valid = r_out_vld;
    assign o_out_ch.res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_vld <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in <= i_in_ch.item;
        end
    end

    ibt_core #(
        .DELAY_BITS (DELAY_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (fire),
        .i_half_bit (half_bit),
        .i_item     (r_in),
        .o_res      (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_res;
        end
    end

    // a stepped item always shows up as a result next cycle
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("stepped item did not reach result register");

    // a finished or aborted transfer is no longer busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.byte_done) |-> !r_out.busy_res)
        else $error("byte_done reported while still busy");

    // SDA is only driven during a transfer
    a_sda_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.sda_pull_low) |-> r_out.busy_res)
        else $error("SDA pulled low outside a transfer");

    // the input register never drops an item while the result stage stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !fire) |=> r_in_vld)
        else $error("pending item lost");

endmodule
